// ----- design/thpc_pkg.sv -----
// thpc_pkg: shared types, constants and the compensation microprogram
// for the THP sensor compensation unit. No dependencies.
package thpc_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [19:0] raw_value;
  } thpc_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] result_value;
    logic        divide_fault;
  } thpc_out_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_TEMP    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_L = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_M = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_H = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM_W   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HUM_N   = 3'd5;

  localparam logic [1:0] KIND_TEMP  = 2'd0;
  localparam logic [1:0] KIND_PRESS = 2'd1;
  localparam logic [1:0] KIND_HUM   = 2'd2;

  localparam logic [31:0] HUM_MAX = 32'd419430400;

  // coefficient selects for U_LDC
  localparam logic [4:0] C_T1 = 5'd0;
  localparam logic [4:0] C_T2 = 5'd1;
  localparam logic [4:0] C_T3 = 5'd2;
  localparam logic [4:0] C_P1 = 5'd3;
  localparam logic [4:0] C_P2 = 5'd4;
  localparam logic [4:0] C_P3 = 5'd5;
  localparam logic [4:0] C_P4 = 5'd6;
  localparam logic [4:0] C_P5 = 5'd7;
  localparam logic [4:0] C_P6 = 5'd8;
  localparam logic [4:0] C_P7 = 5'd9;
  localparam logic [4:0] C_P8 = 5'd10;
  localparam logic [4:0] C_P9 = 5'd11;
  localparam logic [4:0] C_H1 = 5'd12;
  localparam logic [4:0] C_H2 = 5'd13;
  localparam logic [4:0] C_H3 = 5'd14;
  localparam logic [4:0] C_H4 = 5'd15;
  localparam logic [4:0] C_H5 = 5'd16;
  localparam logic [4:0] C_H6 = 5'd17;

  typedef logic [7:0] pc_t;

  localparam pc_t PC_TEMP  = 8'd0;
  localparam pc_t PC_PRESS = 8'd28;
  localparam pc_t PC_FAULT = 8'd78;
  localparam pc_t PC_HUM   = 8'd80;
  localparam pc_t PC_NONE  = 8'd131;

  typedef enum logic [3:0] {
    U_RAW, U_LDI, U_LDC, U_LFT, U_SFT, U_ADD, U_SUB, U_MUL,
    U_DIV, U_SRA, U_SHL, U_SX, U_CLP, U_BZ, U_OUT
  } uop_e;

  typedef struct packed {
    uop_e        opc;
    logic [3:0]  dst;
    logic [3:0]  src_a;
    logic [3:0]  src_b;
    logic [31:0] imm;
  } uop_t;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_WAIT} ctrl_state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic start;
    logic out_load;
    uop_t uop;
  } thpc_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } thpc_sts_t;

  function automatic uop_t mk(uop_e o, int d, int a, int b, int i);
    uop_t u;
    u.opc   = o;
    u.dst   = 4'(d);
    u.src_a = 4'(a);
    u.src_b = 4'(b);
    u.imm   = 32'(i);
    return u;
  endfunction

  // 32-bit steps run on 64-bit registers and are re-extended with U_SX
  // before any arithmetic shift.
  function automatic uop_t ucode(pc_t pc);
    uop_t u;
    case (pc)
      // temperature
      8'd0:   u = mk(U_RAW, 0, 0, 0, 0);
      8'd1:   u = mk(U_SRA, 1, 0, 0, 3);
      8'd2:   u = mk(U_LDC, 2, 0, 0, int'(C_T1));
      8'd3:   u = mk(U_SHL, 3, 2, 0, 1);
      8'd4:   u = mk(U_SUB, 1, 1, 3, 0);
      8'd5:   u = mk(U_LDC, 3, 0, 0, int'(C_T2));
      8'd6:   u = mk(U_MUL, 1, 1, 3, 0);
      8'd7:   u = mk(U_SX,  1, 1, 0, 0);
      8'd8:   u = mk(U_SRA, 1, 1, 0, 11);
      8'd9:   u = mk(U_SRA, 4, 0, 0, 4);
      8'd10:  u = mk(U_SUB, 4, 4, 2, 0);
      8'd11:  u = mk(U_MUL, 4, 4, 4, 0);
      8'd12:  u = mk(U_SX,  4, 4, 0, 0);
      8'd13:  u = mk(U_SRA, 4, 4, 0, 12);
      8'd14:  u = mk(U_LDC, 3, 0, 0, int'(C_T3));
      8'd15:  u = mk(U_MUL, 4, 4, 3, 0);
      8'd16:  u = mk(U_SX,  4, 4, 0, 0);
      8'd17:  u = mk(U_SRA, 4, 4, 0, 14);
      8'd18:  u = mk(U_ADD, 1, 1, 4, 0);
      8'd19:  u = mk(U_SX,  1, 1, 0, 0);
      8'd20:  u = mk(U_SFT, 0, 1, 0, 0);
      8'd21:  u = mk(U_LDI, 3, 0, 0, 5);
      8'd22:  u = mk(U_MUL, 1, 1, 3, 0);
      8'd23:  u = mk(U_LDI, 3, 0, 0, 128);
      8'd24:  u = mk(U_ADD, 1, 1, 3, 0);
      8'd25:  u = mk(U_SX,  1, 1, 0, 0);
      8'd26:  u = mk(U_SRA, 1, 1, 0, 8);
      8'd27:  u = mk(U_OUT, 0, 1, 0, 0);
      // pressure, 64-bit
      8'd28:  u = mk(U_LFT, 0, 0, 0, 0);
      8'd29:  u = mk(U_LDI, 1, 0, 0, 128000);
      8'd30:  u = mk(U_SUB, 0, 0, 1, 0);
      8'd31:  u = mk(U_MUL, 1, 0, 0, 0);
      8'd32:  u = mk(U_LDC, 2, 0, 0, int'(C_P6));
      8'd33:  u = mk(U_MUL, 2, 1, 2, 0);
      8'd34:  u = mk(U_LDC, 3, 0, 0, int'(C_P5));
      8'd35:  u = mk(U_MUL, 3, 0, 3, 0);
      8'd36:  u = mk(U_SHL, 3, 3, 0, 17);
      8'd37:  u = mk(U_ADD, 2, 2, 3, 0);
      8'd38:  u = mk(U_LDC, 3, 0, 0, int'(C_P4));
      8'd39:  u = mk(U_SHL, 3, 3, 0, 35);
      8'd40:  u = mk(U_ADD, 2, 2, 3, 0);
      8'd41:  u = mk(U_LDC, 3, 0, 0, int'(C_P3));
      8'd42:  u = mk(U_MUL, 3, 1, 3, 0);
      8'd43:  u = mk(U_SRA, 3, 3, 0, 8);
      8'd44:  u = mk(U_LDC, 4, 0, 0, int'(C_P2));
      8'd45:  u = mk(U_MUL, 4, 0, 4, 0);
      8'd46:  u = mk(U_SHL, 4, 4, 0, 12);
      8'd47:  u = mk(U_ADD, 3, 3, 4, 0);
      8'd48:  u = mk(U_LDI, 4, 0, 0, 1);
      8'd49:  u = mk(U_SHL, 4, 4, 0, 47);
      8'd50:  u = mk(U_ADD, 3, 3, 4, 0);
      8'd51:  u = mk(U_LDC, 4, 0, 0, int'(C_P1));
      8'd52:  u = mk(U_MUL, 3, 3, 4, 0);
      8'd53:  u = mk(U_SRA, 3, 3, 0, 33);
      8'd54:  u = mk(U_BZ,  0, 3, 0, int'(PC_FAULT));
      8'd55:  u = mk(U_LDI, 4, 0, 0, 1048576);
      8'd56:  u = mk(U_RAW, 5, 0, 0, 0);
      8'd57:  u = mk(U_SUB, 4, 4, 5, 0);
      8'd58:  u = mk(U_SHL, 4, 4, 0, 31);
      8'd59:  u = mk(U_SUB, 4, 4, 2, 0);
      8'd60:  u = mk(U_LDI, 5, 0, 0, 3125);
      8'd61:  u = mk(U_MUL, 4, 4, 5, 0);
      8'd62:  u = mk(U_DIV, 4, 4, 3, 0);
      8'd63:  u = mk(U_SRA, 5, 4, 0, 13);
      8'd64:  u = mk(U_LDC, 6, 0, 0, int'(C_P9));
      8'd65:  u = mk(U_MUL, 6, 6, 5, 0);
      8'd66:  u = mk(U_MUL, 6, 6, 5, 0);
      8'd67:  u = mk(U_SRA, 6, 6, 0, 25);
      8'd68:  u = mk(U_LDC, 7, 0, 0, int'(C_P8));
      8'd69:  u = mk(U_MUL, 7, 7, 4, 0);
      8'd70:  u = mk(U_SRA, 7, 7, 0, 19);
      8'd71:  u = mk(U_ADD, 4, 4, 6, 0);
      8'd72:  u = mk(U_ADD, 4, 4, 7, 0);
      8'd73:  u = mk(U_SRA, 4, 4, 0, 8);
      8'd74:  u = mk(U_LDC, 6, 0, 0, int'(C_P7));
      8'd75:  u = mk(U_SHL, 6, 6, 0, 4);
      8'd76:  u = mk(U_ADD, 4, 4, 6, 0);
      8'd77:  u = mk(U_OUT, 0, 4, 0, 0);
      8'd78:  u = mk(U_LDI, 0, 0, 0, 0);
      8'd79:  u = mk(U_OUT, 0, 0, 0, 1);
      // humidity
      8'd80:  u = mk(U_LFT, 0, 0, 0, 0);
      8'd81:  u = mk(U_LDI, 1, 0, 0, 76800);
      8'd82:  u = mk(U_SUB, 0, 0, 1, 0);
      8'd83:  u = mk(U_SX,  0, 0, 0, 0);
      8'd84:  u = mk(U_RAW, 1, 0, 0, 0);
      8'd85:  u = mk(U_SHL, 1, 1, 0, 14);
      8'd86:  u = mk(U_LDC, 2, 0, 0, int'(C_H4));
      8'd87:  u = mk(U_SHL, 2, 2, 0, 20);
      8'd88:  u = mk(U_SUB, 1, 1, 2, 0);
      8'd89:  u = mk(U_LDC, 2, 0, 0, int'(C_H5));
      8'd90:  u = mk(U_MUL, 2, 2, 0, 0);
      8'd91:  u = mk(U_SUB, 1, 1, 2, 0);
      8'd92:  u = mk(U_LDI, 2, 0, 0, 16384);
      8'd93:  u = mk(U_ADD, 1, 1, 2, 0);
      8'd94:  u = mk(U_SX,  1, 1, 0, 0);
      8'd95:  u = mk(U_SRA, 1, 1, 0, 15);
      8'd96:  u = mk(U_LDC, 2, 0, 0, int'(C_H6));
      8'd97:  u = mk(U_MUL, 2, 0, 2, 0);
      8'd98:  u = mk(U_SX,  2, 2, 0, 0);
      8'd99:  u = mk(U_SRA, 2, 2, 0, 10);
      8'd100: u = mk(U_LDC, 3, 0, 0, int'(C_H3));
      8'd101: u = mk(U_MUL, 3, 0, 3, 0);
      8'd102: u = mk(U_SX,  3, 3, 0, 0);
      8'd103: u = mk(U_SRA, 3, 3, 0, 11);
      8'd104: u = mk(U_LDI, 4, 0, 0, 32768);
      8'd105: u = mk(U_ADD, 3, 3, 4, 0);
      8'd106: u = mk(U_MUL, 2, 2, 3, 0);
      8'd107: u = mk(U_SX,  2, 2, 0, 0);
      8'd108: u = mk(U_SRA, 2, 2, 0, 10);
      8'd109: u = mk(U_LDI, 4, 0, 0, 2097152);
      8'd110: u = mk(U_ADD, 2, 2, 4, 0);
      8'd111: u = mk(U_LDC, 4, 0, 0, int'(C_H2));
      8'd112: u = mk(U_MUL, 2, 2, 4, 0);
      8'd113: u = mk(U_LDI, 4, 0, 0, 8192);
      8'd114: u = mk(U_ADD, 2, 2, 4, 0);
      8'd115: u = mk(U_SX,  2, 2, 0, 0);
      8'd116: u = mk(U_SRA, 2, 2, 0, 14);
      8'd117: u = mk(U_MUL, 1, 1, 2, 0);
      8'd118: u = mk(U_SX,  1, 1, 0, 0);
      8'd119: u = mk(U_SRA, 2, 1, 0, 15);
      8'd120: u = mk(U_MUL, 2, 2, 2, 0);
      8'd121: u = mk(U_SX,  2, 2, 0, 0);
      8'd122: u = mk(U_SRA, 2, 2, 0, 7);
      8'd123: u = mk(U_LDC, 3, 0, 0, int'(C_H1));
      8'd124: u = mk(U_MUL, 2, 2, 3, 0);
      8'd125: u = mk(U_SX,  2, 2, 0, 0);
      8'd126: u = mk(U_SRA, 2, 2, 0, 4);
      8'd127: u = mk(U_SUB, 1, 1, 2, 0);
      8'd128: u = mk(U_CLP, 1, 1, 0, 0);
      8'd129: u = mk(U_SRA, 1, 1, 0, 12);
      8'd130: u = mk(U_OUT, 0, 1, 0, 0);
      // unused kind
      8'd131: u = mk(U_LDI, 0, 0, 0, 0);
      8'd132: u = mk(U_OUT, 0, 0, 0, 0);
      default: u = mk(U_OUT, 0, 0, 0, 0);
    endcase
    return u;
  endfunction

endpackage

// ----- design/thpc_datapath.sv -----
// thpc_datapath: coefficient registers, operand register file, ALU,
// 64x16 iterative multiplier, 64-bit restoring divider and result register.
// Depends on thpc_pkg.
module thpc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [thpc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [thpc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  thpc_pkg::thpc_in_t               in_data_i,
  input  thpc_pkg::thpc_cmd_t              cmd_i,
  output thpc_pkg::thpc_sts_t              sts_o,
  output thpc_pkg::thpc_out_t              out_data_o
);
  import thpc_pkg::*;

  logic [47:0] temp_q, pl_q, pm_q, ph_q;
  logic [39:0] hw_q;
  logic [23:0] hn_q;
  logic [31:0] ft_q;
  logic [1:0]  kind_q;
  logic [19:0] raw_q;
  logic [63:0] rf [16];
  logic [63:0] opa_q, opb_q;
  thpc_out_t   out_q;

  logic [63:0] mc_q, mp_q, acc_q, mul_res;
  logic [1:0]  mcnt_q;
  logic        mbusy_q, mul_done;

  logic [63:0] dd_q, dv_q, rem_q, quo_next, div_res;
  logic [64:0] rem_sh;
  logic        qbit, dneg_q, dbusy_q, div_done;
  logic [5:0]  dcnt_q;

  logic [63:0] coef, alu, wd;
  logic        we;
  uop_t        u;

  assign u = cmd_i.uop;

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx12(logic [11:0] v);
    return {{52{v[11]}}, v};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pl_q   <= '0;
      pm_q   <= '0;
      ph_q   <= '0;
      hw_q   <= '0;
      hn_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEMP:    temp_q <= cfg_wdata_i;
        REG_PRESS_L: pl_q   <= cfg_wdata_i;
        REG_PRESS_M: pm_q   <= cfg_wdata_i;
        REG_PRESS_H: ph_q   <= cfg_wdata_i;
        REG_HUM_W:   hw_q   <= cfg_wdata_i[39:0];
        REG_HUM_N:   hn_q   <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (u.imm[4:0])
      C_T1:    coef = {48'd0, temp_q[15:0]};
      C_T2:    coef = sx16(temp_q[31:16]);
      C_T3:    coef = sx16(temp_q[47:32]);
      C_P1:    coef = {48'd0, pl_q[15:0]};
      C_P2:    coef = sx16(pl_q[31:16]);
      C_P3:    coef = sx16(pl_q[47:32]);
      C_P4:    coef = sx16(pm_q[15:0]);
      C_P5:    coef = sx16(pm_q[31:16]);
      C_P6:    coef = sx16(pm_q[47:32]);
      C_P7:    coef = sx16(ph_q[15:0]);
      C_P8:    coef = sx16(ph_q[31:16]);
      C_P9:    coef = sx16(ph_q[47:32]);
      C_H1:    coef = {56'd0, hn_q[7:0]};
      C_H2:    coef = sx16(hw_q[15:0]);
      C_H3:    coef = {56'd0, hn_q[15:8]};
      C_H4:    coef = sx12(hw_q[27:16]);
      C_H5:    coef = sx12(hw_q[39:28]);
      C_H6:    coef = {{56{hn_q[23]}}, hn_q[23:16]};
      default: coef = '0;
    endcase
  end

  always_comb begin
    case (u.opc)
      U_RAW:   alu = {44'd0, raw_q};
      U_LDI:   alu = {{32{u.imm[31]}}, u.imm};
      U_LDC:   alu = coef;
      U_LFT:   alu = {{32{ft_q[31]}}, ft_q};
      U_ADD:   alu = opa_q + opb_q;
      U_SUB:   alu = opa_q - opb_q;
      U_SRA:   alu = 64'($signed(opa_q) >>> u.imm[5:0]);
      U_SHL:   alu = opa_q << u.imm[5:0];
      U_SX:    alu = {{32{opa_q[31]}}, opa_q[31:0]};
      U_CLP: begin
        if (opa_q[31])                alu = '0;
        else if (opa_q[31:0] > HUM_MAX) alu = {32'd0, HUM_MAX};
        else                          alu = {32'd0, opa_q[31:0]};
      end
      default: alu = '0;
    endcase
  end

  // multiplier: one 16-bit slice of the second operand per cycle
  assign mul_res  = acc_q + 64'(mc_q * mp_q[15:0]);
  assign mul_done = mbusy_q && (mcnt_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mcnt_q  <= '0;
    end else if (cmd_i.start && u.opc == U_MUL) begin
      mbusy_q <= 1'b1;
      mcnt_q  <= '0;
    end else if (mbusy_q) begin
      mcnt_q <= mcnt_q + 2'd1;
      if (mul_done) mbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && u.opc == U_MUL) begin
      mc_q  <= opa_q;
      mp_q  <= opb_q;
      acc_q <= '0;
    end else if (mbusy_q) begin
      acc_q <= mul_res;
      mc_q  <= mc_q << 16;
      mp_q  <= mp_q >> 16;
    end
  end

  // divider: magnitudes, one quotient bit per cycle, sign fixed at the end
  assign rem_sh   = {rem_q, dd_q[63]};
  assign qbit     = rem_sh >= {1'b0, dv_q};
  assign quo_next = {dd_q[62:0], qbit};
  assign div_res  = dneg_q ? (~quo_next + 64'd1) : quo_next;
  assign div_done = dbusy_q && (dcnt_q == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.start && u.opc == U_DIV) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= '0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + 6'd1;
      if (div_done) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start && u.opc == U_DIV) begin
      dd_q   <= opa_q[63] ? (~opa_q + 64'd1) : opa_q;
      dv_q   <= opb_q[63] ? (~opb_q + 64'd1) : opb_q;
      dneg_q <= opa_q[63] ^ opb_q[63];
      rem_q  <= '0;
    end else if (dbusy_q) begin
      rem_q <= qbit ? 64'(rem_sh - {1'b0, dv_q}) : rem_sh[63:0];
      dd_q  <= quo_next;
    end
  end

  assign we = (cmd_i.exec && u.opc != U_SFT) || mul_done || div_done;
  assign wd = mul_done ? mul_res : (div_done ? div_res : alu);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      opa_q <= rf[u.src_a];
      opb_q <= rf[u.src_b];
    end
    if (we) rf[u.dst] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q <= '0;
    end else if (cmd_i.exec && u.opc == U_SFT) begin
      ft_q <= opa_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i.op;
      raw_q  <= in_data_i.raw_value;
    end
    if (cmd_i.out_load) begin
      out_q.result_kind  <= kind_q;
      out_q.result_value <= opa_q[31:0];
      out_q.divide_fault <= u.imm[0];
    end
  end

  assign sts_o.done = mul_done || div_done;
  assign sts_o.zero = (opa_q == 64'd0);
  assign out_data_o = out_q;

endmodule

// ----- design/thpc_ctrl.sv -----
// thpc_ctrl: microprogram sequencer for the compensation unit; owns the
// input and output handshakes. Depends on thpc_pkg.
module thpc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_op_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output thpc_pkg::thpc_cmd_t   cmd_o,
  input  thpc_pkg::thpc_sts_t   sts_i
);
  import thpc_pkg::*;

  ctrl_state_e state_q, state_d;
  pc_t         pc_q, pc_d;
  logic        out_valid_q, out_valid_d;
  uop_t        uop;

  assign uop = ucode(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.uop   = uop;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
          case (in_op_i)
            KIND_TEMP:  pc_d = PC_TEMP;
            KIND_PRESS: pc_d = PC_PRESS;
            KIND_HUM:   pc_d = PC_HUM;
            default:    pc_d = PC_NONE;
          endcase
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        case (uop.opc)
          U_MUL, U_DIV: begin
            cmd_o.start = 1'b1;
            state_d     = S_WAIT;
          end
          U_BZ: begin
            pc_d    = sts_i.zero ? uop.imm[7:0] : pc_q + 8'd1;
            state_d = S_READ;
          end
          U_OUT: begin
            // hold until the previous result has been taken
            if (!(out_valid_q && out_stall_i)) begin
              cmd_o.out_load = 1'b1;
              out_valid_d    = 1'b1;
              state_d        = S_IDLE;
            end
          end
          default: begin
            cmd_o.exec = 1'b1;
            pc_d       = pc_q + 8'd1;
            state_d    = S_READ;
          end
        endcase
      end
      S_WAIT: begin
        if (sts_i.done) begin
          pc_d    = pc_q + 8'd1;
          state_d = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- design/thp_sensor_compensation_unit.sv -----
// thp_sensor_compensation_unit: top level of the THP compensation block.
// Depends on thpc_pkg, thpc_ctrl and thpc_datapath.

// Takes one raw reading (temperature, pressure or humidity) per transfer and
// returns one compensated result per transfer. Readings are processed one at
// a time by a microprogram: each micro-op has a read and an execute state, a
// multiply then waits for its 64x16 slices and the pressure divide for its
// quotient bits (one quotient bit a cycle). A pressure reading skips the
// divide when the divisor is zero. A new reading is accepted as soon as
// the previous one has been handed to the output register, even while that
// result still waits to be taken. Temperature readings update the stored
// fine temperature used by later pressure and humidity readings.
module thp_sensor_compensation_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  thpc_pkg::thpc_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output thpc_pkg::thpc_out_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [thpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [thpc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import thpc_pkg::*;

  thpc_cmd_t cmd;
  thpc_sts_t sts;

  thpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  thpc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("result loaded but not valid");

  a_done_in_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.done |-> (in_stall_o && !cmd.start))
    else $error("unit finished outside an item");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.exec && cmd.start) && !(cmd.load && cmd.rd))
    else $error("conflicting datapath commands");
`endif

endmodule
